### rtl/abs_rtt_pkg.sv
package abs_rtt_pkg;

    localparam int RTT_W = 32;

    // reset value of the round-trip estimate: 10.0 units in sixteenths
    localparam logic [RTT_W-1:0] RESET_RTT = 32'd160;

    typedef enum logic [1:0] {
        OP_MSG     = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        TMR_LEAVE = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } t_tmr;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } t_fifo_sts;

    typedef struct packed {
        logic update;
        logic mark_leave;
        logic clean_set;
        logic clean_clr;
    } t_est_ctl;

    // est + 4*dev, saturated at all ones
    function automatic logic [RTT_W-1:0] timeout_len(input logic [RTT_W-1:0] est,
                                                     input logic [RTT_W-1:0] dev);
        logic [RTT_W+2:0] sum;
        sum = {3'b000, est} + {1'b0, dev, 2'b00};
        if (sum[RTT_W+2:RTT_W] != 3'b000) begin
            return {RTT_W{1'b1}};
        end
        return sum[RTT_W-1:0];
    endfunction

endpackage

### rtl/abs_rtt_fifo.sv
module abs_rtt_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  abs_rtt_pkg::t_fifo_ctl i_ctl,
    input  logic [WIDTH-1:0]       i_push_data,
    output abs_rtt_pkg::t_fifo_sts o_sts,
    output logic [WIDTH-1:0]       o_new_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [WIDTH-1:0] r_head_data;   // copy of the entry at r_head
    logic [WIDTH-1:0] r_next_data;   // prefetch of the entry after r_head

    logic [AW-1:0]    n_head;
    logic [CW-1:0]    n_count;
    logic [AW-1:0]    inc1;
    logic [AW-1:0]    inc2;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    function automatic logic [AW-1:0] wrap(input logic [CW-1:0] x);
        logic [CW-1:0] d;
        d = x - CW'(DEPTH);
        if (x >= CW'(DEPTH)) begin
            return d[AW-1:0];
        end
        return x[AW-1:0];
    endfunction

    always_comb begin
        inc1  = wrap({1'b0, r_head} + CW'(1));
        inc2  = wrap({1'b0, inc1} + CW'(1));
        waddr = wrap({1'b0, r_head} + r_count);
        raddr = i_ctl.pop ? inc2 : inc1;

        n_head  = i_ctl.pop ? inc1 : r_head;
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end

        if (i_ctl.push && (r_count == '0)) begin
            o_new_head = i_push_data;
        end else if (i_ctl.pop) begin
            o_new_head = r_next_data;
        end else begin
            o_new_head = r_head_data;
        end

        o_sts.empty = (r_count == '0);
        o_sts.full  = (r_count == CW'(DEPTH));
        o_sts.one   = (r_count == CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // storage, head copy and the registered prefetch read with write bypass
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[waddr] <= i_push_data;
        end
        if (i_ctl.push && (waddr == raddr)) begin
            r_next_data <= i_push_data;
        end else begin
            r_next_data <= r_mem[raddr];
        end
        r_head_data <= o_new_head;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_sts.full)
        else $error("push into full fifo");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_sts.empty)
        else $error("pop from empty fifo");
`endif

endmodule

### rtl/abs_rtt_est.sv
module abs_rtt_est (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [abs_rtt_pkg::RTT_W-1:0]    i_cfg_data,
    input  abs_rtt_pkg::t_est_ctl            i_ctl,
    input  logic [abs_rtt_pkg::RTT_W-1:0]    i_now,
    output logic                             o_clean,
    output logic [abs_rtt_pkg::RTT_W-1:0]    o_est,
    output logic [abs_rtt_pkg::RTT_W-1:0]    o_dev
);

    localparam int W = abs_rtt_pkg::RTT_W;

    logic [W-1:0] r_est;
    logic [W-1:0] r_dev;
    logic [W-1:0] r_leave;
    logic         r_clean;

    logic [W-1:0] sample;
    logic [W-1:0] diff;
    logic [W+2:0] est_sum;
    logic [W+2:0] dev_sum;
    logic [W-1:0] n_est;
    logic [W-1:0] n_dev;

    // 7/8 old + 1/8 new, deviation taken against the old estimate
    always_comb begin
        sample  = i_now - r_leave;
        diff    = (r_est >= sample) ? (r_est - sample) : (sample - r_est);
        est_sum = {r_est, 3'b000} - {3'b000, r_est} + {3'b000, sample};
        dev_sum = {r_dev, 3'b000} - {3'b000, r_dev} + {3'b000, diff};
        n_est   = i_ctl.update ? est_sum[W+2:3] : r_est;
        n_dev   = i_ctl.update ? dev_sum[W+2:3] : r_dev;
        o_est   = n_est;
        o_dev   = n_dev;
        o_clean = r_clean;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est   <= abs_rtt_pkg::RESET_RTT;
            r_dev   <= '0;
            r_leave <= '0;
            r_clean <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_est <= i_cfg_data;
            end else begin
                r_est <= n_est;
            end
            r_dev <= n_dev;
            if (i_ctl.mark_leave) begin
                r_leave <= i_now;
            end
            if (i_ctl.clean_set) begin
                r_clean <= 1'b1;
            end else if (i_ctl.clean_clr) begin
                r_clean <= 1'b0;
            end
        end
    end

endmodule

### rtl/alternating_bit_sender_rtt.sv
// Alternating-bit sender with adaptive retransmit timeout.
// Input channel (i_in_valid / o_in_stall) carries one event per transaction:
// a new message (queued, sent at once if the queue was empty), an arriving
// ack (pops and flips the sequence bit when intact and carrying the other bit), or a timer
// expiry (resends the head, the next round-trip sample is discarded).
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// event: send flag, sequence bit, payload, timer command and timeout length.
// The input register captures each accepted transaction; one pass of decode,
// queue and estimator logic then carries it into the result register.
// Throughput: one event per cycle while the receiver does not stall; the queue
// head is held in a register with a prefetched successor so consecutive pops
// need no stall.
// A receiver stall holds the result register; the input register keeps
// accepting until it is also full, then o_in_stall rises.
// Reset (i_rst_n low, synchronous) empties the queue, clears the sequence
// bit and deviation, and loads the estimate with 160 (10.0 units).
// i_cfg_we loads a new starting estimate; write it only while idle.
module alternating_bit_sender_rtt #(
    parameter int FIFO_DEPTH = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_data,
    // event channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_op,
    input  logic [DATA_WIDTH-1:0] i_message_data,
    input  logic                  i_ack_intact,
    input  logic                  i_ack_number,
    input  logic [31:0]           i_now,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_send,
    output logic                  o_send_seq,
    output logic [DATA_WIDTH-1:0] o_send_data,
    output logic [1:0]            o_timer_action,
    output logic [31:0]           o_timer_length,
    output logic                  o_dropped
);

    localparam int W = abs_rtt_pkg::RTT_W;

    // input register
    logic                  r_in_valid;
    abs_rtt_pkg::t_op      r_op;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_intact;
    logic                  r_acknum;
    logic [W-1:0]          r_now;

    // protocol state
    logic                  r_seq_bit;
    logic                  n_seq_bit;

    // result register; estimate snapshot feeds the timeout adder
    logic                  r_out_valid;
    logic                  r_send;
    logic                  r_seq;
    logic [DATA_WIDTH-1:0] r_sdata;
    abs_rtt_pkg::t_tmr     r_act;
    logic [W-1:0]          r_est_snap;
    logic [W-1:0]          r_dev_snap;
    logic                  r_drop;

    logic                  n_send;
    logic                  n_seq;
    logic [DATA_WIDTH-1:0] n_sdata;
    abs_rtt_pkg::t_tmr     n_act;
    logic                  n_drop;

    logic                   core_stall;
    logic                   fire;
    logic                   ack_ok;
    abs_rtt_pkg::t_fifo_ctl fctl;
    abs_rtt_pkg::t_fifo_sts fsts;
    abs_rtt_pkg::t_est_ctl  ectl;
    logic [DATA_WIDTH-1:0]  new_head;
    logic                   clean;
    logic [W-1:0]           est_post;
    logic [W-1:0]           dev_post;

    assign core_stall = r_out_valid && i_out_stall;
    assign o_in_stall = r_in_valid && core_stall;
    assign fire       = r_in_valid && !core_stall;

    abs_rtt_fifo #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fctl),
        .i_push_data (r_data),
        .o_sts       (fsts),
        .o_new_head  (new_head)
    );

    abs_rtt_est u_est (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ectl),
        .i_now      (r_now),
        .o_clean    (clean),
        .o_est      (est_post),
        .o_dev      (dev_post)
    );

    // event decode
    always_comb begin
        fctl      = '0;
        ectl      = '0;
        n_seq_bit = r_seq_bit;
        n_send    = 1'b0;
        n_seq     = 1'b0;
        n_sdata   = '0;
        n_act     = abs_rtt_pkg::TMR_LEAVE;
        n_drop    = 1'b0;
        ack_ok    = r_intact && (r_acknum != r_seq_bit);

        unique case (r_op)
            abs_rtt_pkg::OP_MSG: begin
                if (fsts.full) begin
                    n_drop = 1'b1;
                end else begin
                    fctl.push = 1'b1;
                    if (fsts.empty) begin
                        n_send          = 1'b1;
                        n_seq           = r_seq_bit;
                        n_sdata         = new_head;
                        n_act           = abs_rtt_pkg::TMR_START;
                        ectl.mark_leave = 1'b1;
                        ectl.clean_set  = 1'b1;
                    end
                end
            end
            abs_rtt_pkg::OP_ACK: begin
                if (ack_ok) begin
                    fctl.pop    = !fsts.empty;
                    n_seq_bit   = !r_seq_bit;
                    ectl.update = clean;
                end
                // something still queued after the optional pop
                if (!fsts.empty && !(ack_ok && fsts.one)) begin
                    n_send          = 1'b1;
                    n_seq           = n_seq_bit;
                    n_sdata         = new_head;
                    n_act           = abs_rtt_pkg::TMR_START;
                    ectl.mark_leave = 1'b1;
                    ectl.clean_set  = 1'b1;
                end else begin
                    n_act = abs_rtt_pkg::TMR_STOP;
                end
            end
            abs_rtt_pkg::OP_TIMEOUT: begin
                if (!fsts.empty) begin
                    n_send         = 1'b1;
                    n_seq          = r_seq_bit;
                    n_sdata        = new_head;
                    n_act          = abs_rtt_pkg::TMR_START;
                    ectl.clean_clr = 1'b1;   // retransmitted: sample unusable
                end else begin
                    n_act = abs_rtt_pkg::TMR_STOP;
                end
            end
            default: begin
                // unused event code: all-zero result
            end
        endcase

        if (!fire) begin
            fctl      = '0;
            ectl      = '0;
            n_seq_bit = r_seq_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seq_bit   <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_seq_bit <= n_seq_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op     <= abs_rtt_pkg::t_op'(i_op);
            r_data   <= i_message_data;
            r_intact <= i_ack_intact;
            r_acknum <= i_ack_number;
            r_now    <= i_now;
        end
        if (fire) begin
            r_send     <= n_send;
            r_seq      <= n_seq;
            r_sdata    <= n_sdata;
            r_act      <= n_act;
            r_drop     <= n_drop;
            r_est_snap <= est_post;
            r_dev_snap <= dev_post;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_send         = r_send;
    assign o_send_seq     = r_seq;
    assign o_send_data    = r_sdata;
    assign o_timer_action = r_act;
    assign o_dropped      = r_drop;
    assign o_timer_length = (r_act == abs_rtt_pkg::TMR_START)
                          ? abs_rtt_pkg::timeout_len(r_est_snap, r_dev_snap) : '0;

`ifndef SYNTHESIS
    a_send_starts_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send) |-> (o_timer_action == abs_rtt_pkg::TMR_START))
        else $error("send without timer start");

    a_seq_flip_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_op == abs_rtt_pkg::OP_ACK) && ack_ok) |=> (r_seq_bit != $past(r_seq_bit)))
        else $error("accepted ack did not flip sequence bit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_send)
            && $stable(o_send_seq) && $stable(o_send_data) && $stable(o_timer_action)
            && $stable(o_timer_length) && $stable(o_dropped)))
        else $error("result changed while stalled");
`endif

endmodule

### test/tb_alternating_bit_sender_rtt.sv
`timescale 1ns / 100ps

localparam int MSG_W  = 64;
localparam int QDEPTH = 16;

// one result transaction, field by field
typedef struct {
    logic              send;
    logic              seq;
    logic [MSG_W-1:0]  data;
    abs_rtt_pkg::t_tmr tmr;
    logic [31:0]       length;
    logic              dropped;
} t_reply;

// Tracks the sender state, predicts one reply per accepted event and checks
// the replies in order.
class abp_sender_scoreboard;
    logic             seq_bit;
    logic [MSG_W-1:0] msg_queue [QDEPTH];
    logic [3:0]       q_head;
    logic [4:0]       q_count;
    logic [31:0]      rtt_est;
    logic [31:0]      rtt_dev;
    logic             sample_ok;
    logic [31:0]      sent_at;
    t_reply           awaited [$];
    int               errors;
    int               shown;
    int               n_events [4];
    int               n_dropped;
    int               n_saturated;
    int               n_settings;

    function new();
        seq_bit   = 1'b0;
        q_head    = '0;
        q_count   = '0;
        rtt_est   = abs_rtt_pkg::RESET_RTT;
        rtt_dev   = '0;
        sample_ok = 1'b0;
        sent_at   = '0;
        errors    = 0;
        shown     = 0;
        foreach (n_events[i]) n_events[i] = 0;
        n_dropped   = 0;
        n_saturated = 0;
        n_settings  = 0;
    endfunction

    function void load_initial_rtt(input logic [31:0] value);
        rtt_est = value;
        n_settings++;
    endfunction

    function void report(input string msg);
        errors++;
        if (shown < 10) begin
            shown++;
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // est + 4*dev, clipped to 32 bits
    function logic [31:0] retx_timeout();
        logic [34:0] total;
        total = 35'(rtt_est) + (35'(rtt_dev) << 2);
        if (total > 35'h0_FFFF_FFFF) begin
            return 32'hFFFF_FFFF;
        end
        return total[31:0];
    endfunction

    // fold one round-trip sample in; deviation is taken against the old estimate
    function void fold_sample(input logic [31:0] now);
        logic [31:0] smp;
        logic [31:0] diff;
        logic [34:0] est_acc;
        logic [34:0] dev_acc;
        smp     = now - sent_at;
        diff    = (rtt_est >= smp) ? rtt_est - smp : smp - rtt_est;
        est_acc = 35'(rtt_est) * 35'd7 + 35'(smp);
        dev_acc = 35'(rtt_dev) * 35'd7 + 35'(diff);
        rtt_est = est_acc[34:3];
        rtt_dev = dev_acc[34:3];
    endfunction

    function t_reply quiet_reply();
        t_reply r;
        r.send    = 1'b0;
        r.seq     = 1'b0;
        r.data    = '0;
        r.tmr     = abs_rtt_pkg::TMR_LEAVE;
        r.length  = '0;
        r.dropped = 1'b0;
        return r;
    endfunction

    function t_reply head_send();
        t_reply r;
        r        = quiet_reply();
        r.send   = 1'b1;
        r.seq    = seq_bit;
        r.data   = msg_queue[q_head];
        r.tmr    = abs_rtt_pkg::TMR_START;
        r.length = retx_timeout();
        return r;
    endfunction

    function void note_event(input logic [1:0] op, input logic [MSG_W-1:0] data,
                             input logic intact, input logic ack_num,
                             input logic [31:0] now);
        t_reply     r;
        logic [3:0] slot;
        r = quiet_reply();
        n_events[op]++;
        case (op)
            abs_rtt_pkg::OP_MSG: begin
                if (q_count == 5'(QDEPTH)) begin
                    r.dropped = 1'b1;
                    n_dropped++;
                end else begin
                    slot            = q_head + q_count[3:0];
                    msg_queue[slot] = data;
                    q_count++;
                    if (q_count == 5'd1) begin
                        r         = head_send();
                        sent_at   = now;
                        sample_ok = 1'b1;
                    end
                end
            end
            abs_rtt_pkg::OP_ACK: begin
                if (intact && ack_num != seq_bit) begin
                    if (q_count != 0) begin
                        q_head++;
                        q_count--;
                    end
                    seq_bit = ~seq_bit;
                    if (sample_ok) fold_sample(now);
                end
                if (q_count != 0) begin
                    r         = head_send();
                    sent_at   = now;
                    sample_ok = 1'b1;
                end else begin
                    r.tmr = abs_rtt_pkg::TMR_STOP;
                end
            end
            abs_rtt_pkg::OP_TIMEOUT: begin
                // resend, and the next sample is ambiguous
                if (q_count != 0) begin
                    r         = head_send();
                    sample_ok = 1'b0;
                end else begin
                    r.tmr = abs_rtt_pkg::TMR_STOP;
                end
            end
            default: ;
        endcase
        if (r.tmr == abs_rtt_pkg::TMR_START && r.length == 32'hFFFF_FFFF) n_saturated++;
        awaited.push_back(r);
    endfunction

    function void check_reply(input t_reply got);
        t_reply want;
        if (awaited.size() == 0) begin
            report($sformatf("unexpected result send=%b data=%h tmr=%0d", got.send,
                             got.data, got.tmr));
            return;
        end
        want = awaited.pop_front();
        if (got.send !== want.send || got.seq !== want.seq || got.data !== want.data ||
            got.tmr !== want.tmr || got.length !== want.length ||
            got.dropped !== want.dropped) begin
            report($sformatf({"result mismatch: expected send=%b seq=%b data=%h tmr=%0d ",
                              "len=%h drop=%b, got send=%b seq=%b data=%h tmr=%0d ",
                              "len=%h drop=%b"},
                             want.send, want.seq, want.data, want.tmr, want.length,
                             want.dropped, got.send, got.seq, got.data, got.tmr,
                             got.length, got.dropped));
        end
    endfunction
endclass

module tb_alternating_bit_sender_rtt;

    localparam int CYCLE_LIMIT = 200000;
    // op code the block decodes to nothing
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // event mixes for the random part
    localparam int MIX_EVEN  = 0;
    localparam int MIX_FILL  = 1;
    localparam int MIX_DRAIN = 2;
    // idle styles for both sides
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_RANDOM = 1;
    localparam int IDLE_RARE   = 2;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [31:0]      i_cfg_data     = '0;
    logic             i_in_valid     = 1'b0;
    logic [1:0]       i_op           = '0;
    logic [MSG_W-1:0] i_message_data = '0;
    logic             i_ack_intact   = 1'b0;
    logic             i_ack_number   = 1'b0;
    logic [31:0]      i_now          = '0;
    logic             i_out_stall    = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic             o_send;
    logic             o_send_seq;
    logic [MSG_W-1:0] o_send_data;
    logic [1:0]       o_timer_action;
    logic [31:0]      o_timer_length;
    logic             o_dropped;

    abp_sender_scoreboard sb = new();

    int          cycle_count       = 0;
    int          backpressure      = 0;   // cycles an offered event sat stalled
    int          long_hold_cycles  = 0;   // one-shot request to the result sink
    int          sender_style      = IDLE_RANDOM;
    logic [31:0] wall_clock;              // running protocol time for i_now

    alternating_bit_sender_rtt dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_message_data (i_message_data),
        .i_ack_intact   (i_ack_intact),
        .i_ack_number   (i_ack_number),
        .i_now          (i_now),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_send         (o_send),
        .o_send_seq     (o_send_seq),
        .o_send_data    (o_send_data),
        .o_timer_action (o_timer_action),
        .o_timer_length (o_timer_length),
        .o_dropped      (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    // watchdog plus a count of input backpressure
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_in_valid && o_in_stall) backpressure++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // every result transaction goes to the scoreboard
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.send    = o_send;
            got.seq     = o_send_seq;
            got.data    = o_send_data;
            got.tmr     = abs_rtt_pkg::t_tmr'(o_timer_action);
            got.length  = o_timer_length;
            got.dropped = o_dropped;
            sb.check_reply(got);
        end
    end

    function automatic int draw_gap(input int style);
        case (style)
            IDLE_NONE:   return 0;
            IDLE_RARE:   return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 17) : 0;
            default:     return $urandom_range(0, 17);
        endcase
    endfunction

    // Result sink: draws a wait per transaction; a long-hold request replaces
    // one draw with a long stretch of stall so the pipeline backs up.
    initial begin : result_sink
        int wait_n;
        int style;
        int served;
        served = 0;
        style  = IDLE_RANDOM;
        forever begin
            if (served % 32 == 0) style = $urandom_range(0, 2);
            if (long_hold_cycles > 0) begin
                wait_n           = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                wait_n = draw_gap(style);
            end
            repeat (wait_n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            served++;
        end
    end

    // Offers one event and returns once it has been accepted. Valid stays up
    // afterwards; the caller's idle gap or the next offer decides what follows.
    task automatic offer_event(input logic [1:0] op, input logic [MSG_W-1:0] data,
                               input logic intact, input logic ack_num,
                               input logic [31:0] now);
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_message_data <= data;
        i_ack_intact   <= intact;
        i_ack_number   <= ack_num;
        i_now          <= now;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_event(op, data, intact, ack_num, now);
    endtask

    task automatic sender_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // ack that the sender will take: intact and carrying the other bit
    task automatic offer_good_ack(input logic [31:0] now);
        offer_event(abs_rtt_pkg::OP_ACK, {$urandom, $urandom}, 1'b1, ~sb.seq_bit, now);
        sender_gap(draw_gap(sender_style));
    endtask

    task automatic offer_msg(input logic [MSG_W-1:0] data, input logic [31:0] now);
        offer_event(abs_rtt_pkg::OP_MSG, data, $urandom_range(0, 1),
                    $urandom_range(0, 1), now);
        sender_gap(draw_gap(sender_style));
    endtask

    // mostly small steps in time, now and then a jump anywhere in the range
    function automatic logic [31:0] tick_clock();
        if ($urandom_range(0, 9) == 0) begin
            wall_clock = $urandom;
        end else begin
            wall_clock = wall_clock + $urandom_range(0, 400);
        end
        return wall_clock;
    endfunction

    task automatic random_event(input int mix);
        int         pick;
        int         msg_cut;
        int         ack_cut;
        logic [1:0] op;
        logic       intact;
        logic       ack_num;
        pick    = $urandom_range(0, 99);
        msg_cut = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 15 : 40;
        ack_cut = (mix == MIX_FILL) ? 88 : (mix == MIX_DRAIN) ? 85 : 80;
        if (pick < msg_cut) begin
            op = abs_rtt_pkg::OP_MSG;
        end else if (pick < ack_cut) begin
            op = abs_rtt_pkg::OP_ACK;
        end else if (pick < 97) begin
            op = abs_rtt_pkg::OP_TIMEOUT;
        end else begin
            op = OP_UNUSED;
        end
        // most acks are the expected one, the rest carry a random intact flag and number
        if (op == abs_rtt_pkg::OP_ACK && $urandom_range(0, 4) != 0) begin
            intact  = 1'b1;
            ack_num = ~sb.seq_bit;
        end else begin
            intact  = $urandom_range(0, 1);
            ack_num = $urandom_range(0, 1);
        end
        offer_event(op, {$urandom, $urandom}, intact, ack_num, tick_clock());
        sender_gap(draw_gap(sender_style));
    endtask

    // drop valid and wait until every expected result has come back
    task automatic wait_for_replies();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        // keep a margin of idle clocks after the last result
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_initial_rtt(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.load_initial_rtt(value);
    endtask

    initial begin : stimulus
        logic [31:0] rtt_settings [6];
        int          mix;

        rtt_settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom, 32'd4000,
                         abs_rtt_pkg::RESET_RTT};
        wall_clock   = $urandom;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, reset value of initial_rtt ----
        // timeout with nothing in flight: timer stops
        offer_event(abs_rtt_pkg::OP_TIMEOUT, '0, 1'b0, 1'b0, 32'h0);
        // ack taken with the queue empty and no clean sample: bit flips only
        offer_event(abs_rtt_pkg::OP_ACK, '1, 1'b1, ~sb.seq_bit, 32'hFFFF_FFFF);
        // unused op code: quiet result
        offer_event(OP_UNUSED, '1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // first message goes out at once, second only queues
        offer_event(abs_rtt_pkg::OP_MSG, '1, 1'b0, 1'b0, 32'hFFFF_FFF0);
        offer_event(abs_rtt_pkg::OP_MSG, '0, 1'b1, 1'b1, 32'hFFFF_FFF8);
        // corrupt ack, then an intact ack with the stale bit: both resend
        offer_event(abs_rtt_pkg::OP_ACK, '0, 1'b0, ~sb.seq_bit, 32'hFFFF_FFFC);
        offer_event(abs_rtt_pkg::OP_ACK, '0, 1'b1, sb.seq_bit, 32'hFFFF_FFFE);
        // timeout resends and taints the sample
        offer_event(abs_rtt_pkg::OP_TIMEOUT, '0, 1'b0, 1'b0, 32'h0000_0004);
        // good ack across the time wrap: pops, no estimate update
        offer_good_ack(32'h0000_0010);
        // good ack with a clean sample, queue goes empty: update and stop
        offer_good_ack(32'h0000_0090);
        // accepted ack on an empty queue still updates the estimate
        offer_good_ack(32'h0000_0100);
        // fill the queue and overflow it by one
        for (int k = 0; k <= QDEPTH; k++) begin
            offer_msg((k % 2 == 0) ? {32{2'b10}} : {32{2'b01}}, 32'h200 + 32'(k));
        end
        wait_for_replies();

        // ---- random phases, one per initial_rtt setting ----
        foreach (rtt_settings[p]) begin
            write_initial_rtt(rtt_settings[p]);
            if (p == 1) begin
                // stall the results for a long stretch while events keep coming
                long_hold_cycles = 80;
                sender_style     = IDLE_NONE;
                repeat (24) random_event(MIX_FILL);
            end
            for (int n = 0; n < 80; n++) begin
                if (n % 20 == 0) begin
                    mix          = $urandom_range(MIX_EVEN, MIX_DRAIN);
                    sender_style = $urandom_range(IDLE_NONE, IDLE_RARE);
                end
                random_event(mix);
            end
            wait_for_replies();
        end

        $display("covered %0d events: %0d messages (%0d dropped), %0d acks, %0d timeouts, %0d other",
                 sb.n_events[0] + sb.n_events[1] + sb.n_events[2] + sb.n_events[3],
                 sb.n_events[abs_rtt_pkg::OP_MSG], sb.n_dropped,
                 sb.n_events[abs_rtt_pkg::OP_ACK],
                 sb.n_events[abs_rtt_pkg::OP_TIMEOUT], sb.n_events[OP_UNUSED]);
        $display("%0d initial_rtt writes, %0d saturated timeouts, %0d stalled input cycles",
                 sb.n_settings, sb.n_saturated, backpressure);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
